>>> hdl/fdsf_pkg.sv
// Shared types, constants and glyph functions of the four-digit segment display formatter.
package fdsf_pkg;

  localparam int unsigned NumDigits = 4;
  localparam int unsigned NumWrites = NumDigits + 1;
  localparam int unsigned BeatW     = $clog2(NumWrites);

  localparam logic [7:0] AddrControl = 8'h48;
  localparam logic [7:0] ColonBit    = 8'h80;
  localparam logic [3:0] CtrlOnBits  = 4'h1;

  localparam logic [NumDigits-1:0][7:0] DigitAddr = {8'h6E, 8'h6C, 8'h6A, 8'h68};

  typedef enum logic [1:0] {
    CfgBrightness = 2'd0,
    CfgRotate     = 2'd1,
    CfgMirror     = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [4:0] glyph_zero;
    logic [4:0] glyph_one;
    logic [4:0] glyph_two;
    logic [4:0] glyph_three;
    logic       colon_on;
    logic       display_off;
  } item_t;

  typedef struct packed {
    logic [7:0] command_address;
    logic [7:0] command_data;
    logic       last_write;
  } result_t;

  typedef struct packed {
    logic [2:0] brightness_level;
    logic       rotate_enable;
    logic       mirror_enable;
  } cfg_t;

  typedef struct packed {
    logic [7:0]                 ctrl;
    logic [NumDigits-1:0][7:0]  pat;
  } frame_t;

  function automatic logic [7:0] glyph_lookup(input logic [4:0] idx);
    logic [7:0] g;
    unique case (idx)
      5'd0:  g = 8'h3F;
      5'd1:  g = 8'h06;
      5'd2:  g = 8'h5B;
      5'd3:  g = 8'h4F;
      5'd4:  g = 8'h66;
      5'd5:  g = 8'h6D;
      5'd6:  g = 8'h7D;
      5'd7:  g = 8'h07;
      5'd8:  g = 8'h7F;
      5'd9:  g = 8'h6F;
      5'd10: g = 8'h77;
      5'd11: g = 8'h7C;
      5'd12: g = 8'h39;
      5'd13: g = 8'h5E;
      5'd14: g = 8'h79;
      5'd15: g = 8'h71;
      5'd16: g = 8'h76;
      5'd17: g = 8'h38;
      5'd18: g = 8'h50;
      5'd19: g = 8'h73;
      5'd20: g = 8'h37;
      5'd21: g = 8'h40;
      5'd22: g = 8'h01;
      5'd23: g = 8'h08;
      5'd24: g = 8'h63;
      5'd25: g = 8'h5C;
      5'd26: g = 8'h3E;
      5'd27: g = 8'h58;
      5'd28: g = 8'h6B;
      5'd29: g = 8'h5D;
      5'd30: g = 8'h00;
      5'd31: g = 8'h00;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

  // 180 degree turn: a<->d, b<->e, c<->f; decimal point dropped
  function automatic logic [7:0] turn_glyph(input logic [7:0] p);
    return {1'b0, p[6], p[2:0], p[5:3]};
  endfunction

  // top-to-bottom flip: a<->d, b<->c, e<->f
  function automatic logic [7:0] flip_glyph(input logic [7:0] p);
    return {p[7:6], p[4], p[5], p[0], p[1], p[2], p[3]};
  endfunction

endpackage

>>> hdl/fdsf_cfg_regs.sv
// Configuration register bank: brightness, rotation and mirror settings.
module fdsf_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [2:0]        cfg_data_i,
  output fdsf_pkg::cfg_t    cfg_o
);
  import fdsf_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgBrightness: cfg_d.brightness_level = cfg_data_i;
        CfgRotate:     cfg_d.rotate_enable    = cfg_data_i[0];
        CfgMirror:     cfg_d.mirror_enable    = cfg_data_i[0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hdl/fdsf_glyph_map.sv
// Glyph lookup, rotation, mirroring, colon and control byte for one item.
module fdsf_glyph_map (
  input  fdsf_pkg::item_t   item_i,
  input  fdsf_pkg::cfg_t    cfg_i,
  output fdsf_pkg::frame_t  frame_o
);
  import fdsf_pkg::*;

  logic [NumDigits-1:0][4:0] glyph_in;
  logic [NumDigits-1:0][7:0] pat;
  logic [2:0]                field;

  assign glyph_in = {item_i.glyph_three, item_i.glyph_two, item_i.glyph_one, item_i.glyph_zero};

  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      pat[i] = glyph_lookup(cfg_i.rotate_enable ? glyph_in[NumDigits-1-i] : glyph_in[i]);
      if (cfg_i.rotate_enable) pat[i] = turn_glyph(pat[i]);
      if (cfg_i.mirror_enable) pat[i] = flip_glyph(pat[i]);
    end
    if (item_i.colon_on) pat[1] = pat[1] | ColonBit;
  end

  // code 7 wraps to field 0 (brightest)
  assign field = cfg_i.brightness_level + 3'd1;

  assign frame_o.pat  = pat;
  assign frame_o.ctrl = item_i.display_off ? 8'h00 : {1'b0, field, CtrlOnBits};

endmodule

>>> hdl/fdsf_write_seq.sv
// Frame register and five-beat write sequencer with registered result port.
module fdsf_write_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  fdsf_pkg::frame_t  frame_i,
  output logic              busy_o,
  output logic              result_strobe_o,
  output fdsf_pkg::result_t result_o
);
  import fdsf_pkg::*;

  localparam int unsigned      DigitW   = $clog2(NumDigits);
  localparam logic [BeatW-1:0] LastBeat = BeatW'(NumWrites - 1);

  frame_t            frame_q;
  logic              active_q, active_d;
  logic [BeatW-1:0]  beat_q, beat_d;
  logic              strobe_q, strobe_d;
  result_t           res_q, res_d;
  logic              last_beat;
  logic [BeatW-1:0]  beat_m1;
  logic [DigitW-1:0] digit_sel;

  assign last_beat = (beat_q == LastBeat);
  assign busy_o    = active_q && !last_beat;
  assign beat_m1   = beat_q - BeatW'(1);
  assign digit_sel = beat_m1[DigitW-1:0];

  always_comb begin
    active_d = active_q;
    beat_d   = beat_q;
    strobe_d = active_q;
    res_d    = res_q;
    if (active_q) begin
      res_d.last_write = last_beat;
      if (beat_q == '0) begin
        res_d.command_address = AddrControl;
        res_d.command_data    = frame_q.ctrl;
      end else begin
        res_d.command_address = DigitAddr[digit_sel];
        res_d.command_data    = frame_q.pat[digit_sel];
      end
      beat_d = beat_q + BeatW'(1);
      if (last_beat) active_d = 1'b0;
    end
    if (load_i) begin
      active_d = 1'b1;
      beat_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      beat_q   <= '0;
      strobe_q <= 1'b0;
    end else begin
      active_q <= active_d;
      beat_q   <= beat_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (load_i) frame_q <= frame_i;
  end

  assign result_strobe_o = strobe_q;
  assign result_o        = res_q;

endmodule

>>> hdl/four_digit_segment_display_formatter.sv
// Top level of the four-digit segment display formatter.
// Control byte goes first; load sets active_q, then strobe_q and res_q present it.
// Each item gives five writes on consecutive cycles, the last flagged by last_write.
// A new item is taken only once the current one reaches its last beat:
// busy is low in the cycle of the fifth beat so runs follow without a gap.
// Reset: async active low; clears sequencer state and config, not result data.
module four_digit_segment_display_formatter (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  fdsf_pkg::item_t   item_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [2:0]        cfg_data_i,
  output logic              result_strobe_o,
  output fdsf_pkg::result_t result_o
);
  import fdsf_pkg::*;

  cfg_t   cfg;
  frame_t frame;
  logic   load;

  assign load = start && !busy;

  fdsf_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  fdsf_glyph_map u_map (
    .item_i  (item_i),
    .cfg_i   (cfg),
    .frame_o (frame)
  );

  fdsf_write_seq u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (load),
    .frame_i         (frame),
    .busy_o          (busy),
    .result_strobe_o (result_strobe_o),
    .result_o        (result_o)
  );

endmodule

>>> hdl/fdsf_checker.sv
// Port-level checker for the display formatter, bound to the top level.
module fdsf_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              result_strobe_o,
  input fdsf_pkg::result_t result_o
);
  import fdsf_pkg::*;

  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after start transfer");

  a_control_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> ##1 (result_strobe_o && result_o.command_address == AddrControl))
    else $error("control write missing after start transfer");

  a_run_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && !result_o.last_write |=> result_strobe_o)
    else $error("gap inside a write run");

  a_last_is_final_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && result_o.last_write |-> result_o.command_address == DigitAddr[NumDigits-1])
    else $error("last_write on wrong address");

  a_control_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && result_o.command_address == AddrControl |-> !result_o.last_write)
    else $error("control write flagged last");

endmodule

bind four_digit_segment_display_formatter fdsf_checker u_fdsf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .result_strobe_o (result_strobe_o),
  .result_o        (result_o)
);
